### rtl/bsa_pkg.sv
// Shared types, constants and helper functions of the bipartition set ALU.
package bsa_pkg;

  localparam int unsigned SET_W  = 64;
  localparam int unsigned TAXA_W = 7;

  // Taxa count after reset.
  localparam logic [TAXA_W-1:0] TaxaReset = 7'd64;

  // Operation codes carried in the input tuser.
  typedef enum logic [2:0] {
    OP_CANON   = 3'd0,
    OP_COMBINE = 3'd1,
    OP_COMPARE = 3'd2,
    OP_COMPAT  = 3'd3,
    OP_FILL    = 3'd4
  } bsa_op_e;

  // One input word as it enters the pipeline.
  typedef struct packed {
    logic [2:0]        op;
    logic [SET_W-1:0]  first_set;
    logic [SET_W-1:0]  second_set;
    logic              fill_value;
    logic [TAXA_W-1:0] span;
  } bsa_in_t;

  // Stage one result: masked operands, the set to canonicalize, early flags.
  typedef struct packed {
    logic [2:0]       op;
    logic [SET_W-1:0] a;
    logic [SET_W-1:0] b;
    logic [SET_W-1:0] t;
    logic             compat;
    logic             fail;
  } bsa_prep_t;

  // Stage two result: population counts and the compare tie-break.
  typedef struct packed {
    logic [2:0]        op;
    logic [SET_W-1:0]  a;
    logic [SET_W-1:0]  t;
    logic [TAXA_W-1:0] pop_a;
    logic [TAXA_W-1:0] pop_b;
    logic [TAXA_W-1:0] pop_t;
    logic              eq;
    logic              low_in_a;
    logic              compat;
    logic              fail;
  } bsa_count_t;

  // Final result word.
  typedef struct packed {
    logic [SET_W-1:0]  result_set;
    logic [TAXA_W-1:0] set_size;
    logic              is_less;
    logic              is_equal;
    logic              is_compatible;
    logic              cannot_combine;
  } bsa_out_t;

  // Mask with the low k bits set; k of 64 or more gives all ones.
  function automatic logic [SET_W-1:0] low_mask(logic [TAXA_W-1:0] k);
    logic [SET_W-1:0] m;
    for (int i = 0; i < SET_W; i++) begin
      m[i] = (TAXA_W'(i) < k);
    end
    return m;
  endfunction

endpackage

### rtl/bsa_prep.sv
// First pipeline stage: operand masking, join selection, fill and span tests.
module bsa_prep (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic [bsa_pkg::TAXA_W-1:0]         n_i,
  input  logic [bsa_pkg::SET_W-1:0]          mask_i,
  input  logic                               valid_i,
  output logic                               ready_o,
  input  bsa_pkg::bsa_in_t                   data_i,
  output logic                               valid_o,
  input  logic                               ready_i,
  output bsa_pkg::bsa_prep_t                 data_o
);
  import bsa_pkg::*;

  logic [SET_W-1:0]  a, b, na, nb, t, x, y, sm;
  logic [TAXA_W-1:0] sp;
  logic              fail, compat;
  logic              valid_q;
  bsa_prep_t         data_d, data_q;

  // Mask operands, build the set that later gets canonicalized, and set the compat and fail flags.
  always_comb begin
    a      = data_i.first_set & mask_i;
    b      = data_i.second_set & mask_i;
    na     = ~a & mask_i;
    nb     = ~b & mask_i;
    t      = a;
    fail   = 1'b0;
    compat = 1'b0;
    sp     = (data_i.span < n_i) ? data_i.span : n_i;
    sm     = low_mask(sp);
    x      = a & sm;
    y      = b & sm;
    case (data_i.op)
      OP_COMBINE: begin
        if ((a & b) == '0) begin
          t = a | b;
        end else if ((na & b) == '0) begin
          t = na | b;
        end else begin
          t    = a | nb;
          fail = ((a & nb) != '0);
        end
      end
      OP_FILL: begin
        t = (a & ~b) | (data_i.fill_value ? b : '0);
      end
      OP_COMPAT: begin
        compat = ((x & ~y) == '0) || ((y & ~x) == '0) || ((x & y) == '0) ||
                 ((~x & ~y & sm) == '0);
      end
      default: begin
        t = a;
      end
    endcase
    data_d.op     = data_i.op;
    data_d.a      = a;
    data_d.b      = b;
    data_d.t      = t;
    data_d.compat = compat;
    data_d.fail   = fail;
  end

  assign ready_o = !valid_q || ready_i;

  // Stage register with its valid bit.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_i && ready_o) begin
      data_q <= data_d;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule

### rtl/bsa_count.sv
// Second pipeline stage: population counts and the compare tie-break bit.
module bsa_count (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                valid_i,
  output logic                ready_o,
  input  bsa_pkg::bsa_prep_t  data_i,
  output logic                valid_o,
  input  logic                ready_i,
  output bsa_pkg::bsa_count_t data_o
);
  import bsa_pkg::*;

  // Adder tree over 64 bits, one level per loop and the last level in the return.
  function automatic logic [TAXA_W-1:0] popcnt(logic [SET_W-1:0] v);
    logic [1:0] l1 [32];
    logic [2:0] l2 [16];
    logic [3:0] l3 [8];
    logic [4:0] l4 [4];
    logic [5:0] l5 [2];
    for (int i = 0; i < 32; i++) l1[i] = {1'b0, v[2*i]} + {1'b0, v[2*i+1]};
    for (int i = 0; i < 16; i++) l2[i] = {1'b0, l1[2*i]} + {1'b0, l1[2*i+1]};
    for (int i = 0; i < 8; i++)  l3[i] = {1'b0, l2[2*i]} + {1'b0, l2[2*i+1]};
    for (int i = 0; i < 4; i++)  l4[i] = {1'b0, l3[2*i]} + {1'b0, l3[2*i+1]};
    for (int i = 0; i < 2; i++)  l5[i] = {1'b0, l4[2*i]} + {1'b0, l4[2*i+1]};
    return {1'b0, l5[0]} + {1'b0, l5[1]};
  endfunction

  logic [SET_W-1:0] d, low;
  logic             valid_q;
  bsa_count_t       data_d, data_q;

  // Counts of both operands and of the join, plus the lowest differing taxon.
  always_comb begin
    d                = data_i.a ^ data_i.b;
    low              = d & (~d + 64'd1);
    data_d.op        = data_i.op;
    data_d.a         = data_i.a;
    data_d.t         = data_i.t;
    data_d.pop_a     = popcnt(data_i.a);
    data_d.pop_b     = popcnt(data_i.b);
    data_d.pop_t     = popcnt(data_i.t);
    data_d.eq        = (data_i.op == OP_COMPARE) && (d == '0);
    data_d.low_in_a  = ((data_i.a & low) != '0);
    data_d.compat    = data_i.compat;
    data_d.fail      = data_i.fail;
  end

  assign ready_o = !valid_q || ready_i;

  // Stage register with its valid bit.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_i && ready_o) begin
      data_q <= data_d;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule

### rtl/bsa_final.sv
// Third pipeline stage: canonical inversion, result size, compare order; output register.
module bsa_final (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic [bsa_pkg::TAXA_W-1:0]  n_i,
  input  logic [bsa_pkg::SET_W-1:0]   mask_i,
  input  logic                        valid_i,
  output logic                        ready_o,
  input  bsa_pkg::bsa_count_t         data_i,
  output logic                        valid_o,
  input  logic                        ready_i,
  output bsa_pkg::bsa_out_t           data_o
);
  import bsa_pkg::*;

  logic     canon_op, inv, less;
  logic     valid_q;
  bsa_out_t data_d, data_q;

  // A set with more than half of the taxa is inverted within the mask.
  always_comb begin
    canon_op = (data_i.op == OP_CANON) || (data_i.op == OP_COMBINE) ||
               (data_i.op == OP_FILL);
    inv      = ({data_i.pop_t, 1'b0} > {1'b0, n_i});
    if (data_i.pop_a < data_i.pop_b) begin
      less = 1'b1;
    end else if (data_i.pop_a > data_i.pop_b) begin
      less = 1'b0;
    end else if (data_i.eq) begin
      less = 1'b0;
    end else begin
      less = !data_i.low_in_a;
    end
    if (canon_op) begin
      data_d.result_set = inv ? (~data_i.t & mask_i) : data_i.t;
      data_d.set_size   = inv ? (n_i - data_i.pop_t) : data_i.pop_t;
    end else begin
      data_d.result_set = data_i.a;
      data_d.set_size   = data_i.pop_a;
    end
    data_d.is_less        = (data_i.op == OP_COMPARE) && less;
    data_d.is_equal       = data_i.eq;
    data_d.is_compatible  = data_i.compat;
    data_d.cannot_combine = data_i.fail;
  end

  assign ready_o = !valid_q || ready_i;

  // Output register; holds the word while the receiver stalls.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_i && ready_o) begin
      data_q <= data_d;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule

### rtl/bipartition_set_alu.sv
// Top level of the bipartition set ALU: config register and three-stage pipeline.
//
// The block applies one set operation to each input word and returns one
// result word. The input stream carries the operation in tuser and the two
// 64-bit taxon sets, the fill value and the span in tdata. The output stream
// carries the result set, its size and four flags in tdata.
// The taxa count register is written through cfg_we_i / cfg_wdata_i only
// while no word is in flight, a rule on the user that the block does not
// enforce; it resets to 64, and the count in use is clamped to MAX_TAXA.
// Words pass in order through three register stages (masking and join,
// popcount trees, canonical inversion) at one word per cycle unless the
// receiver stalls; a stage takes a word when empty or its successor moves.
// When the receiver stalls the output register holds its word, the stages
// behind it fill up, and s_axis_tready drops only once all three are full;
// nothing is lost or repeated. Reset empties the pipeline and restores the
// taxa count.
module bipartition_set_alu #(
  parameter int unsigned MAX_TAXA = 64
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  // Configuration: taxa count.
  input  logic         cfg_we_i,
  input  logic [6:0]   cfg_wdata_i,
  // Input words.
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // [63:0] first_set, [127:64] second_set, [128] fill_value, [135:129] span
  input  logic [135:0] s_axis_tdata,
  // [2:0] operation
  input  logic [2:0]   s_axis_tuser,
  // Result words.
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // [63:0] result_set, [70:64] set_size, [71] is_less, [72] is_equal,
  // [73] is_compatible, [74] cannot_combine, [79:75] zero
  output logic [79:0]  m_axis_tdata
);
  import bsa_pkg::*;

  logic [TAXA_W-1:0] taxa_q, taxa_d, n;
  logic [SET_W-1:0]  mask;
  bsa_in_t           in_word;
  logic              p_valid, p_ready, c_valid, c_ready;
  bsa_prep_t         p_data;
  bsa_count_t        c_data;
  bsa_out_t          out_word;

  // Taxa count register.
  assign taxa_d = cfg_we_i ? cfg_wdata_i : taxa_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      taxa_q <= TaxaReset;
    end else begin
      taxa_q <= taxa_d;
    end
  end

  // Taxa in use and their mask.
  assign n    = (taxa_q > TAXA_W'(MAX_TAXA)) ? TAXA_W'(MAX_TAXA) : taxa_q;
  assign mask = low_mask(n);

  // Unpack the input word.
  assign in_word.op         = s_axis_tuser;
  assign in_word.first_set  = s_axis_tdata[63:0];
  assign in_word.second_set = s_axis_tdata[127:64];
  assign in_word.fill_value = s_axis_tdata[128];
  assign in_word.span       = s_axis_tdata[135:129];

  bsa_prep u_prep (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .n_i     (n),
    .mask_i  (mask),
    .valid_i (s_axis_tvalid),
    .ready_o (s_axis_tready),
    .data_i  (in_word),
    .valid_o (p_valid),
    .ready_i (p_ready),
    .data_o  (p_data)
  );

  bsa_count u_count (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (p_valid),
    .ready_o (p_ready),
    .data_i  (p_data),
    .valid_o (c_valid),
    .ready_i (c_ready),
    .data_o  (c_data)
  );

  bsa_final u_final (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .n_i     (n),
    .mask_i  (mask),
    .valid_i (c_valid),
    .ready_o (c_ready),
    .data_i  (c_data),
    .valid_o (m_axis_tvalid),
    .ready_i (m_axis_tready),
    .data_o  (out_word)
  );

  // Pack the result word.
  assign m_axis_tdata = {5'b0, out_word.cannot_combine, out_word.is_compatible,
                         out_word.is_equal, out_word.is_less, out_word.set_size,
                         out_word.result_set};

endmodule

### rtl/bsa_checker.sv
// Port-level checks of the bipartition set ALU, bound to the top level.
module bsa_checker (
  input logic         clk_i,
  input logic         rst_ni,
  input logic         m_axis_tvalid,
  input logic         m_axis_tready,
  input logic [79:0]  m_axis_tdata
);

  // A stalled result word stays put.
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result word changed while stalled");

  // The size field is the population count of the result set.
  a_size: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (m_axis_tdata[70:64] == 7'($countones(m_axis_tdata[63:0]))))
    else $error("set size does not match result set");

  // Strictly before and equal exclude each other.
  a_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> !(m_axis_tdata[71] && m_axis_tdata[72]))
    else $error("compare reports both less and equal");

  // Flags of different operations never appear together.
  a_flags: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> $onehot0({m_axis_tdata[71] || m_axis_tdata[72],
                                m_axis_tdata[73], m_axis_tdata[74]}))
    else $error("flags of different operations set together");

endmodule

bind bipartition_set_alu bsa_checker u_bsa_checker (.*);

### tb/bipartition_set_alu_test.sv
// Self-checking testbench for the bipartition set ALU: random and directed words, scoreboard.
module bipartition_set_alu_test;
  import bsa_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned TaxaLimit = 64;
  localparam int unsigned WordsPerSetting = 150;
  localparam int unsigned CycleLimit = 500000;
  // Largest operation code the 3-bit tuser can carry; codes above OP_FILL are unused.
  localparam logic [2:0] OpCodeTop = 3'd7;
  localparam logic [SET_W-1:0] AllTaxa = '1;

  // Receiver behavior, chosen anew for each stretch of cycles.
  typedef enum logic [1:0] {
    RX_ALWAYS,
    RX_MOSTLY,
    RX_RARELY,
    RX_PATTERN
  } rx_style_e;

  logic         clk_i = 1'b0;
  logic         rst_ni = 1'b0;
  logic         cfg_we_i = 1'b0;
  logic [6:0]   cfg_wdata_i = '0;
  logic         s_axis_tvalid = 1'b0;
  logic         s_axis_tready;
  logic [135:0] s_axis_tdata = '0;
  logic [2:0]   s_axis_tuser = '0;
  logic         m_axis_tvalid;
  logic         m_axis_tready = 1'b0;
  logic [79:0]  m_axis_tdata;

  bsa_in_t     pending_words[$];
  bsa_out_t    expected_results[$];
  logic [6:0]  taxa_setting = TaxaReset;
  logic        word_taken = 1'b0;
  int unsigned cycle_count = 0;
  int unsigned mismatch_count = 0;
  int unsigned settings_tried = 1;
  int unsigned op_tally[8];
  int unsigned burst_left = 0;
  int unsigned gap_left = 0;
  int unsigned stall_left = 0;
  rx_style_e   rx_style = RX_ALWAYS;
  logic [31:0] rx_pattern = '1;

  bipartition_set_alu #(
    .MAX_TAXA(TaxaLimit)
  ) DUT (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // Mask of the low k taxa; 64 or more selects every bit.
  function automatic logic [SET_W-1:0] taxa_mask(int unsigned k);
    if (k >= SET_W) return '1;
    return (64'd1 << k) - 64'd1;
  endfunction

  // Keep the smaller side: invert within the used taxa when more than half are set.
  function automatic logic [SET_W-1:0] canonical_side(logic [SET_W-1:0] s, int unsigned n,
                                                      logic [SET_W-1:0] m);
    s = s & m;
    if ($countones(s) * 2 > n) s = ~s & m;
    return s;
  endfunction

  // Expected result word for one input word under the given taxa count.
  function automatic bsa_out_t bipartition_outcome(bsa_in_t w, logic [6:0] taxa_reg);
    int unsigned n;
    int unsigned pop_a;
    int unsigned pop_b;
    logic [SET_W-1:0] m, a, b, na, nb, t, d, sm, x, y, res;
    bsa_out_t o;
    n = (taxa_reg > TaxaLimit) ? TaxaLimit : taxa_reg;
    m = taxa_mask(n);
    a = w.first_set & m;
    b = w.second_set & m;
    res = a;
    o = '0;
    case (w.op)
      OP_CANON: res = canonical_side(a, n, m);
      OP_COMBINE: begin
        na = ~a & m;
        nb = ~b & m;
        if ((a & b) == '0) t = a | b;
        else if ((na & b) == '0) t = na | b;
        else begin
          t = a | nb;
          o.cannot_combine = ((a & nb) != '0);
        end
        res = canonical_side(t, n, m);
      end
      OP_COMPARE: begin
        pop_a = $countones(a);
        pop_b = $countones(b);
        d = a ^ b;
        o.is_equal = (d == '0);
        // Equal sizes: the set lacking the lowest differing taxon orders first.
        if (pop_a != pop_b) o.is_less = (pop_a < pop_b);
        else if (d != '0) o.is_less = ((a & (d & (~d + 64'd1))) == '0);
      end
      OP_COMPAT: begin
        sm = taxa_mask((w.span < n) ? w.span : n);
        x = a & sm;
        y = b & sm;
        o.is_compatible = ((x & ~y) == '0) || ((y & ~x) == '0) || ((x & y) == '0) ||
                          ((~x & ~y & sm) == '0);
      end
      OP_FILL: begin
        t = (a & ~b) | (w.fill_value ? b : '0);
        res = canonical_side(t, n, m);
      end
      default: ;
    endcase
    o.result_set = res & m;
    o.set_size = TAXA_W'($countones(res & m));
    return o;
  endfunction

  // Random taxon set: plain, sparse, dense, a few single taxa, or empty/full.
  function automatic logic [SET_W-1:0] random_taxa_set();
    logic [SET_W-1:0] s;
    case ($urandom_range(0, 5))
      0, 1: s = {$urandom, $urandom};
      2: s = {$urandom, $urandom} & {$urandom, $urandom} & {$urandom, $urandom};
      3: s = {$urandom, $urandom} | {$urandom, $urandom} | {$urandom, $urandom};
      4: begin
        s = '0;
        repeat ($urandom_range(1, 3)) s[$urandom_range(0, SET_W - 1)] = 1'b1;
      end
      default: s = $urandom_range(0, 1) ? AllTaxa : '0;
    endcase
    return s;
  endfunction

  // Random word whose second set is usually related to the first one.
  function automatic bsa_in_t random_word(int unsigned n);
    bsa_in_t w;
    logic [SET_W-1:0] r;
    int unsigned pick;
    pick = $urandom_range(0, 19);
    w.op = (pick < 19) ? 3'(pick % 5) : 3'($urandom_range(OP_FILL + 1, OpCodeTop));
    w.first_set = random_taxa_set();
    r = random_taxa_set();
    case ($urandom_range(0, 7))
      0: w.second_set = w.first_set;
      1: w.second_set = w.first_set & r;
      2: w.second_set = w.first_set | r;
      3: w.second_set = ~w.first_set;
      4: w.second_set = ~w.first_set & r;
      5: w.second_set = {w.first_set[0], w.first_set[SET_W-1:1]};
      6: w.second_set = w.first_set ^ (64'd1 << $urandom_range(0, SET_W - 1));
      default: w.second_set = r;
    endcase
    w.fill_value = 1'($urandom_range(0, 1));
    w.span = ($urandom_range(0, 9) < 6) ? TAXA_W'(n) : TAXA_W'($urandom_range(0, 127));
    return w;
  endfunction

  task automatic queue_word(logic [2:0] op, logic [SET_W-1:0] a, logic [SET_W-1:0] b,
                            logic fv, logic [TAXA_W-1:0] span);
    bsa_in_t w;
    w.op = op;
    w.first_set = a;
    w.second_set = b;
    w.fill_value = fv;
    w.span = span;
    pending_words.push_back(w);
  endtask

  // Hold the sender back until every expected result has come, then let the pipe settle.
  task automatic wait_for_drain();
    while (pending_words.size() != 0 || s_axis_tvalid || expected_results.size() != 0)
      @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_taxa_count(logic [6:0] value);
    @(negedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= value;
    taxa_setting = value;
    settings_tried++;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  // Sender: words go out in bursts, and a word stays on the bus until taken.
  always @(negedge clk_i) begin
    bsa_in_t w;
    logic drive;
    if (rst_ni) begin
      if (word_taken) void'(pending_words.pop_front());
      drive = s_axis_tvalid && !word_taken;
      if (!drive) begin
        if (gap_left != 0) begin
          gap_left--;
        end else if (pending_words.size() != 0) begin
          drive = 1'b1;
          if (burst_left <= 1) begin
            burst_left = $urandom_range(1, 32);
            case ($urandom_range(0, 7))
              0, 1: gap_left = 0;
              7: gap_left = $urandom_range(20, 40);
              default: gap_left = $urandom_range(1, 8);
            endcase
          end else begin
            burst_left--;
          end
        end
      end
      s_axis_tvalid <= drive;
      if (drive) begin
        w = pending_words[0];
        s_axis_tdata <= {w.span, w.fill_value, w.second_set, w.first_set};
        s_axis_tuser <= w.op;
      end
    end
  end

  // Receiver: ready follows a randomly chosen style that is picked anew after each stretch.
  always @(negedge clk_i) begin
    logic rdy;
    if (stall_left == 0) begin
      rx_style = rx_style_e'($urandom_range(0, 3));
      stall_left = $urandom_range(50, 300);
      rx_pattern = $urandom | 32'd1;
    end else begin
      stall_left--;
    end
    case (rx_style)
      RX_ALWAYS: rdy = 1'b1;
      RX_MOSTLY: rdy = ($urandom_range(0, 3) != 0);
      RX_RARELY: rdy = ($urandom_range(0, 3) == 0);
      default: begin
        rdy = rx_pattern[0];
        rx_pattern = {rx_pattern[0], rx_pattern[31:1]};
      end
    endcase
    m_axis_tready <= rdy;
  end

  // Predict on every accepted input word and check every accepted result word.
  always @(posedge clk_i) begin
    bsa_in_t in_word;
    bsa_out_t want;
    cycle_count++;
    word_taken <= s_axis_tvalid && s_axis_tready;
    if (s_axis_tvalid && s_axis_tready) begin
      in_word.op = s_axis_tuser;
      in_word.first_set = s_axis_tdata[63:0];
      in_word.second_set = s_axis_tdata[127:64];
      in_word.fill_value = s_axis_tdata[128];
      in_word.span = s_axis_tdata[135:129];
      expected_results.push_back(bipartition_outcome(in_word, taxa_setting));
      op_tally[s_axis_tuser]++;
    end
    if (m_axis_tvalid && m_axis_tready) begin
      if (expected_results.size() == 0) begin
        $error("result word %h arrived with no result expected", m_axis_tdata);
        mismatch_count++;
      end else begin
        want = expected_results.pop_front();
        if (m_axis_tdata[63:0] !== want.result_set) begin
          $error("result_set: expected %h, got %h", want.result_set, m_axis_tdata[63:0]);
          mismatch_count++;
        end
        if (m_axis_tdata[70:64] !== want.set_size) begin
          $error("set_size: expected %0d, got %0d", want.set_size, m_axis_tdata[70:64]);
          mismatch_count++;
        end
        if (m_axis_tdata[71] !== want.is_less) begin
          $error("is_less: expected %b, got %b", want.is_less, m_axis_tdata[71]);
          mismatch_count++;
        end
        if (m_axis_tdata[72] !== want.is_equal) begin
          $error("is_equal: expected %b, got %b", want.is_equal, m_axis_tdata[72]);
          mismatch_count++;
        end
        if (m_axis_tdata[73] !== want.is_compatible) begin
          $error("is_compatible: expected %b, got %b", want.is_compatible, m_axis_tdata[73]);
          mismatch_count++;
        end
        if (m_axis_tdata[74] !== want.cannot_combine) begin
          $error("cannot_combine: expected %b, got %b", want.cannot_combine, m_axis_tdata[74]);
          mismatch_count++;
        end
      end
    end
    if (cycle_count > CycleLimit) begin
      $display("Timed out after %0d cycles with %0d results outstanding", cycle_count,
               expected_results.size());
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // Stimulus: directed words at the reset taxa count, then random phases per setting.
  initial begin
    logic [6:0] taxa_plan[10];
    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Canonical form of the full and empty sets, at and around the half-way size, and the top taxon alone.
    queue_word(OP_CANON, AllTaxa, '0, 1'b0, 7'd64);
    queue_word(OP_CANON, '0, AllTaxa, 1'b1, 7'd0);
    queue_word(OP_CANON, 64'h0000_0000_FFFF_FFFF, '0, 1'b0, 7'd64);
    queue_word(OP_CANON, 64'h0000_0001_FFFF_FFFF, '0, 1'b0, 7'd64);
    queue_word(OP_CANON, 64'h8000_0000_0000_0000, '0, 1'b0, 7'd64);
    // Each of the three joins, and the case where all of them conflict.
    queue_word(OP_COMBINE, 64'h0F, 64'hF0, 1'b0, 7'd64);
    queue_word(OP_COMBINE, 64'hFF, 64'h0F, 1'b0, 7'd64);
    queue_word(OP_COMBINE, 64'h0F, 64'hFF, 1'b0, 7'd64);
    queue_word(OP_COMBINE, 64'h03, 64'h06, 1'b0, 7'd64);
    // Ordering by size, ties broken at the lowest differing taxon, and equality.
    queue_word(OP_COMPARE, AllTaxa, AllTaxa, 1'b0, 7'd64);
    queue_word(OP_COMPARE, 64'h1, 64'h3, 1'b0, 7'd64);
    queue_word(OP_COMPARE, 64'h3, 64'h1, 1'b0, 7'd64);
    queue_word(OP_COMPARE, 64'h2, 64'h1, 1'b0, 7'd64);
    queue_word(OP_COMPARE, 64'h1, 64'h2, 1'b0, 7'd64);
    // Compatibility with an empty span, a short span, a full span and a saturating span.
    queue_word(OP_COMPAT, 64'h3, 64'h6, 1'b0, 7'd0);
    queue_word(OP_COMPAT, 64'h3, 64'h6, 1'b0, 7'd2);
    queue_word(OP_COMPAT, 64'h3, 64'h6, 1'b0, 7'd64);
    queue_word(OP_COMPAT, 64'hFFFF_0000_FFFF_0000, 64'h0000_FFFF_0000_FFFF, 1'b1, 7'd127);
    // Fill with ones and with zeros.
    queue_word(OP_FILL, 64'h0000_0000_0000_00FF, 64'hFFFF_FFFF_0000_0000, 1'b1, 7'd64);
    queue_word(OP_FILL, AllTaxa, AllTaxa, 1'b0, 7'd64);
    queue_word(OP_FILL, '0, AllTaxa, 1'b1, 7'd127);
    // Unused operation codes pass the masked first set through.
    for (int c = OP_FILL + 1; c <= OpCodeTop; c++) begin
      queue_word(3'(c), AllTaxa, '0, 1'b1, 7'd127);
    end
    wait_for_drain();

    // Taxa count settings: extremes, saturation, odd sizes, then random ones.
    taxa_plan = '{7'd1, 7'd0, 7'd127, 7'd65, 7'd2, 7'd63, 7'd33,
                  7'($urandom_range(3, 62)), 7'($urandom_range(0, 127)), 7'd64};
    foreach (taxa_plan[p]) begin
      write_taxa_count(taxa_plan[p]);
      repeat (WordsPerSetting) begin
        pending_words.push_back(random_word((taxa_plan[p] > TaxaLimit) ? TaxaLimit
                                                                       : taxa_plan[p]));
      end
      wait_for_drain();
    end
    repeat (8) @(posedge clk_i);

    $display("Covered %0d taxa-count settings: canonicalize %0d, combine %0d, compare %0d,",
             settings_tried, op_tally[OP_CANON], op_tally[OP_COMBINE], op_tally[OP_COMPARE]);
    $display("compatible %0d, fill %0d and unused codes %0d words; %0d field mismatches.",
             op_tally[OP_COMPAT], op_tally[OP_FILL],
             op_tally[5] + op_tally[6] + op_tally[OpCodeTop], mismatch_count);
    if (mismatch_count == 0 && expected_results.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
